>>> rtl/core/bmhq_pkg.sv
// Shared types and constants for the binary min-heap priority queue.
// No dependencies; used by every module of the block except bmhq_ram.
package bmhq_pkg;

   // Default sizing, handed down as top-level parameter defaults
   localparam int HEAP_DEPTH_DEF  = 1024;
   localparam int VALUE_WIDTH_DEF = 32;

   // Request codes
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_POP_EMPTY = 2'd1,
      STATUS_PUSH_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic               req_type;
      logic signed [31:0] push_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] min_value;
      logic [10:0]        entry_count;
      logic               is_empty;
      status_type         status;
   } rsp_payload_type;

   // Finished operation, handed from the sift engine to the result register
   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } done_type;

endpackage

>>> rtl/core/bmhq_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module bmhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/bmhq_ctrl.sv
// Sift engine of the min-heap: owns the heap RAM, the fill count and a copy of the root.
// Depends on bmhq_pkg and bmhq_ram.
module bmhq_ctrl #(
   parameter int HEAP_DEPTH  = bmhq_pkg::HEAP_DEPTH_DEF,
   parameter int VALUE_WIDTH = bmhq_pkg::VALUE_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bmhq_pkg::req_payload_type req_data,
   input  logic                      slot_free,
   output bmhq_pkg::done_type        done
);

   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int IW = AW + 2;

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b00_0000_0001,
      ST_UP_RD   = 10'b00_0000_0010,
      ST_UP_CMP  = 10'b00_0000_0100,
      ST_PUT     = 10'b00_0000_1000,
      ST_DN_LAST = 10'b00_0001_0000,
      ST_DN_TOP  = 10'b00_0010_0000,
      ST_DN_CHK  = 10'b00_0100_0000,
      ST_DN_L    = 10'b00_1000_0000,
      ST_DN_R    = 10'b01_0000_0000,
      ST_RESP    = 10'b10_0000_0000
   } state_type;

   state_type                   state_ff, state_in;
   logic [CW-1:0]               n_ff, n_in;
   logic [AW-1:0]               pos_ff, pos_in;
   logic signed [VALUE_WIDTH-1:0] x_ff, x_in;
   logic signed [VALUE_WIDTH-1:0] lv_ff, lv_in;
   logic signed [VALUE_WIDTH-1:0] root_ff, root_in;
   bmhq_pkg::status_type        stat_ff, stat_in;

   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [VALUE_WIDTH-1:0]      wr_data;
   logic                        rd_en;
   logic [AW-1:0]               rd_addr;
   logic [VALUE_WIDTH-1:0]      rd_raw;
   logic signed [VALUE_WIDTH-1:0] rd_val;

   logic [AW-1:0]               parent;
   logic [IW-1:0]               l_idx;
   logic [IW-1:0]               r_idx;
   logic [IW-1:0]               n_ext;
   logic                        go_l;
   logic signed [VALUE_WIDTH-1:0] cand_val;

   bmhq_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (HEAP_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // Tree index arithmetic around the current hole
   assign rd_val   = signed'(rd_raw);
   assign parent   = AW'((pos_ff - AW'(1)) >> 1);
   assign l_idx    = IW'({pos_ff, 1'b1});
   assign r_idx    = l_idx + IW'(1);
   assign n_ext    = IW'(n_ff);
   assign go_l     = lv_ff < x_ff;
   assign cand_val = go_l ? lv_ff : x_ff;

   assign req_ready = (state_ff == ST_IDLE);

   // Next-state and RAM access decode
   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      pos_in   = pos_ff;
      x_in     = x_ff;
      lv_in    = lv_ff;
      stat_in  = stat_ff;
      wr_en    = 1'b0;
      wr_addr  = pos_ff;
      wr_data  = x_ff;
      rd_en    = 1'b0;
      rd_addr  = '0;
      done     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               stat_in = bmhq_pkg::STATUS_OK;
               if (req_data.req_type == bmhq_pkg::REQ_PUSH) begin
                  if (n_ff == CW'(HEAP_DEPTH)) begin
                     stat_in  = bmhq_pkg::STATUS_PUSH_FULL;
                     state_in = ST_RESP;
                  end else begin
                     x_in     = VALUE_WIDTH'(req_data.push_value);
                     pos_in   = AW'(n_ff);
                     n_in     = n_ff + CW'(1);
                     state_in = (n_ff == '0) ? ST_PUT : ST_UP_RD;
                  end
               end else begin
                  if (n_ff == '0) begin
                     stat_in  = bmhq_pkg::STATUS_POP_EMPTY;
                     state_in = ST_RESP;
                  end else begin
                     n_in     = n_ff - CW'(1);
                     state_in = (n_ff == CW'(1)) ? ST_RESP : ST_DN_LAST;
                  end
               end
            end
         end
         ST_UP_RD: begin
            rd_en    = 1'b1;
            rd_addr  = parent;
            state_in = ST_UP_CMP;
         end
         ST_UP_CMP: begin
            // parent moves down into the hole while the new value is smaller
            if (x_ff < rd_val) begin
               wr_en    = 1'b1;
               wr_data  = rd_raw;
               pos_in   = parent;
               state_in = (parent == '0) ? ST_PUT : ST_UP_RD;
            end else begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            wr_en    = 1'b1;
            state_in = ST_RESP;
         end
         ST_DN_LAST: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(n_ff);
            state_in = ST_DN_TOP;
         end
         ST_DN_TOP: begin
            x_in     = rd_val;
            pos_in   = '0;
            state_in = ST_DN_CHK;
         end
         ST_DN_CHK: begin
            if (l_idx < n_ext) begin
               rd_en    = 1'b1;
               rd_addr  = l_idx[AW-1:0];
               state_in = ST_DN_L;
            end else begin
               state_in = ST_PUT;
            end
         end
         ST_DN_L: begin
            lv_in = rd_val;
            if (r_idx < n_ext) begin
               rd_en    = 1'b1;
               rd_addr  = r_idx[AW-1:0];
               state_in = ST_DN_R;
            end else if (rd_val < x_ff) begin
               wr_en    = 1'b1;
               wr_data  = rd_raw;
               pos_in   = l_idx[AW-1:0];
               state_in = ST_DN_CHK;
            end else begin
               state_in = ST_PUT;
            end
         end
         ST_DN_R: begin
            // smaller child wins, left on a tie; stop on equal
            if (rd_val < cand_val) begin
               wr_en    = 1'b1;
               wr_data  = rd_raw;
               pos_in   = r_idx[AW-1:0];
               state_in = ST_DN_CHK;
            end else if (go_l) begin
               wr_en    = 1'b1;
               wr_data  = lv_ff;
               pos_in   = l_idx[AW-1:0];
               state_in = ST_DN_CHK;
            end else begin
               state_in = ST_PUT;
            end
         end
         ST_RESP: begin
            if (slot_free) begin
               done.valid               = 1'b1;
               done.payload.min_value   = (n_ff == '0) ? 32'sd0 : 32'(root_ff);
               done.payload.entry_count = 11'(n_ff);
               done.payload.is_empty    = (n_ff == '0);
               done.payload.status      = stat_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Root shadow follows every write to entry zero
   assign root_in = (wr_en && wr_addr == '0) ? signed'(wr_data) : root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         n_ff     <= '0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      x_ff    <= x_in;
      lv_ff   <= lv_in;
      root_ff <= root_in;
      stat_ff <= stat_in;
   end

endmodule

>>> rtl/core/binary_min_heap_queue.sv
// Binary min-heap priority queue. Each request is a push of a signed value or a pop of the
// minimum; every request yields exactly one result with the new minimum (0 when empty), the
// entry count, an empty flag and a status (pop on empty and push on full change nothing and
// are flagged). The heap lives in one single-port-read RAM with a registered read, so each
// step of a sift is a read, a compare and a write back of the moved entry. A push lets
// the new value climb from the next free leaf toward the root; a pop moves the last entry
// to the root and lets it sink toward a leaf, taking the smaller child at each level. A pop
// that empties the heap, a pop on empty and a push on full do no sift. Requests are taken
// one at a time; a new request is accepted while the previous result still waits for
// transfer, and a result that cannot be handed over stalls the engine.
// Depends on bmhq_pkg, bmhq_ctrl and bmhq_ram.
module binary_min_heap_queue #(
   parameter int HEAP_DEPTH  = bmhq_pkg::HEAP_DEPTH_DEF,
   parameter int VALUE_WIDTH = bmhq_pkg::VALUE_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bmhq_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bmhq_pkg::rsp_payload_type rsp_data
);

   bmhq_pkg::done_type        done;
   logic                      slot_free;
   logic                      rsp_valid_ff;
   bmhq_pkg::rsp_payload_type rsp_data_ff;

   bmhq_ctrl #(
      .HEAP_DEPTH  (HEAP_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .slot_free (slot_free),
      .done      (done)
   );

   // Result register: free when empty or being transferred this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done.valid) begin
         rsp_data_ff <= done.payload;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/core/bmhq_chk.sv
// Port-level checker for binary_min_heap_queue, bound to the top level below.
// Depends on bmhq_pkg.
module bmhq_chk (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input bmhq_pkg::rsp_payload_type rsp_data
);

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Empty flag matches the count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_empty == (rsp_data.entry_count == 11'd0)))
      else $error("empty flag disagrees with entry count");

   // Empty heap shows a zero minimum
   a_empty_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_empty |-> rsp_data.min_value == 32'sd0)
      else $error("nonzero minimum on empty heap");

   // Refused pop only when empty, refused push never when empty
   a_status_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == bmhq_pkg::STATUS_POP_EMPTY |-> rsp_data.is_empty)
      else $error("pop error reported on nonempty heap");

   a_status_push: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == bmhq_pkg::STATUS_PUSH_FULL |-> !rsp_data.is_empty)
      else $error("full error reported on empty heap");

endmodule

bind binary_min_heap_queue bmhq_chk u_bmhq_chk (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
